// ===== sv/epoch_seconds_to_calendar_top_macros.svh =====
// Assertion macros shared by the calendar converter RTL.
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is high.
`define ECAL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("calendar converter assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ECAL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("calendar converter assertion failed");

`else

`define ECAL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ECAL_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== sv/ecal_pkg.sv =====
// Types, widths and constants of the epoch-to-calendar converter.
package ecal_pkg;

   // Pipeline depth.
   localparam int NUM_STAGES = 7;

   // Field widths.
   localparam int SECS_W  = 31;
   localparam int ZONE_W  = 4;
   localparam int YEAR_W  = 11;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;

   // Internal widths.
   localparam int SUM_W  = 32;   // seconds plus zone offset
   localparam int DAYS_W = 15;   // whole days since 1970-01-01
   localparam int SOD_W  = 17;   // second of the day
   localparam int MOD_W  = 11;   // minute of the day
   localparam int Z_W    = 15;   // days since 1968-03-01
   localparam int CYC_W  = 5;    // four-year cycles since 1968-03-01
   localparam int DOC_W  = 11;   // day of the four-year cycle
   localparam int DOY_W  = 9;    // day of the March-based year
   localparam int YOC_W  = 2;    // year of the cycle
   localparam int MP_W   = 4;    // March-based month index

   localparam logic [ZONE_W-1:0] ZONE_RESET = 4'd8;
   localparam logic [SUM_W-1:0] SECS_PER_HOUR = 32'd3600;

   // Day split: 86400 = 2^7 * 675, quotient by 675 from a reciprocal estimate.
   localparam int DAY_LOW_BITS = 7;
   localparam int X_W          = SUM_W - DAY_LOW_BITS;
   localparam int QD_PROD_W    = 2 * X_W;
   localparam int QD_SHIFT     = 34;
   localparam logic [X_W-1:0] RECIP_675 = 25'd25451658;
   localparam logic [X_W-1:0] DIV_675   = 25'd675;
   localparam int REM_W = 11;

   // Divide by 60 with an exact rounded-up reciprocal for values below 2^17.
   localparam int D60_SHIFT = 23;
   localparam int D60_PROD_W = 35;
   localparam logic [D60_PROD_W-1:0] RECIP_60 = 35'd139811;

   // Divide by 1461 (days in four years) with an exact reciprocal.
   localparam int D1461_SHIFT  = 25;
   localparam int D1461_PROD_W = 30;
   localparam logic [D1461_PROD_W-1:0] RECIP_1461 = 30'd22967;
   localparam logic [Z_W-1:0] DAYS_PER_CYCLE = 15'd1461;

   // Days from 1968-03-01 to 1970-01-01, and the base year of that count.
   localparam logic [Z_W-1:0] DAY_BASE_OFFSET = 15'd671;
   localparam logic [YEAR_W-1:0] BASE_YEAR = 11'd1968;
   localparam logic [DOC_W-1:0] DAYS_PER_YEAR = 11'd365;
   localparam logic [DOY_W-1:0] JANUARY_START = 9'd306;

   // Per-stage load enables of the pipeline.
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } ecal_ctl_type;

   // First day of each month in a year that starts on March 1.
   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] idx);
      logic [DOY_W-1:0] start;
      unique case (idx)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd184;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

// ===== sv/ecal_if.sv =====
// Handshake channels of the epoch-to-calendar converter.
interface ecal_req_if;
   import ecal_pkg::*;
   logic                valid;
   logic                ready;
   logic [SECS_W-1:0]   epoch_seconds;
   modport source (output valid, output epoch_seconds, input ready);
   modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_rsp_if;
   import ecal_pkg::*;
   logic                valid;
   logic                ready;
   logic [YEAR_W-1:0]   year_out;
   logic [MONTH_W-1:0]  month_out;
   logic [DAY_W-1:0]    day_out;
   logic [HOUR_W-1:0]   hour_out;
   logic [MIN_W-1:0]    minute_out;
   logic [SEC_W-1:0]    second_out;
   modport source (output valid, output year_out, output month_out, output day_out,
                   output hour_out, output minute_out, output second_out, input ready);
   modport sink (input valid, input year_out, input month_out, input day_out,
                 input hour_out, input minute_out, input second_out, output ready);
endinterface

interface ecal_csr_if;
   import ecal_pkg::*;
   logic                valid;
   logic                ready;
   logic [ZONE_W-1:0]   zone_offset_hours;
   modport source (output valid, output zone_offset_hours, input ready);
   modport sink (input valid, input zone_offset_hours, output ready);
endinterface

// ===== sv/ecal_split.sv =====
// Stages one to three: zone offset add and split into days and second of day.
module ecal_split (
   input  logic                           clock,
   input  ecal_pkg::ecal_ctl_type         ctl,
   input  logic [ecal_pkg::ZONE_W-1:0]    zone_offset_hours,
   input  logic [ecal_pkg::SECS_W-1:0]    epoch_seconds,
   output logic [ecal_pkg::DAYS_W-1:0]    days,
   output logic [ecal_pkg::SOD_W-1:0]     sod
);
   import ecal_pkg::*;

   logic [SUM_W-1:0]     t1_ff, t1_in;
   logic [SUM_W-1:0]     t2_ff;
   logic [DAYS_W-1:0]    qe2_ff, qe2_in;
   logic [DAYS_W-1:0]    days3_ff, days3_in;
   logic [SOD_W-1:0]     sod3_ff, sod3_in;
   logic [QD_PROD_W-1:0] prod2;
   logic [X_W-1:0]       p3;
   logic [X_W-1:0]       r3;
   logic [REM_W-1:0]     rem3;
   logic [REM_W-1:0]     rem3_fix;

   // Stage one: local seconds.
   always_comb begin
      t1_in = SUM_W'(epoch_seconds) + SUM_W'(zone_offset_hours) * SECS_PER_HOUR;
   end

   // Stage two: quotient estimate by 86400, low by at most one.
   always_comb begin
      prod2  = QD_PROD_W'(t1_ff[SUM_W-1:DAY_LOW_BITS]) * QD_PROD_W'(RECIP_675);
      qe2_in = prod2[QD_SHIFT +: DAYS_W];
   end

   // Stage three: remainder, one correction step, and the second of day.
   always_comb begin
      p3       = X_W'(qe2_ff) * DIV_675;
      r3       = t2_ff[SUM_W-1:DAY_LOW_BITS] - p3;
      rem3     = r3[REM_W-1:0];
      rem3_fix = rem3 - REM_W'(DIV_675);
      if (rem3 >= REM_W'(DIV_675)) begin
         days3_in = qe2_ff + DAYS_W'(1);
         sod3_in  = {rem3_fix[SOD_W-DAY_LOW_BITS-1:0], t2_ff[DAY_LOW_BITS-1:0]};
      end else begin
         days3_in = qe2_ff;
         sod3_in  = {rem3[SOD_W-DAY_LOW_BITS-1:0], t2_ff[DAY_LOW_BITS-1:0]};
      end
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         t1_ff <= t1_in;
      end
      if (ctl.load[1]) begin
         t2_ff  <= t1_ff;
         qe2_ff <= qe2_in;
      end
      if (ctl.load[2]) begin
         days3_ff <= days3_in;
         sod3_ff  <= sod3_in;
      end
   end

   assign days = days3_ff;
   assign sod  = sod3_ff;

endmodule

// ===== sv/ecal_tod.sv =====
// Stages four to seven: hour, minute and second from the second of day.
module ecal_tod (
   input  logic                         clock,
   input  ecal_pkg::ecal_ctl_type       ctl,
   input  logic [ecal_pkg::SOD_W-1:0]   sod,
   output logic [ecal_pkg::HOUR_W-1:0]  hour_out,
   output logic [ecal_pkg::MIN_W-1:0]   minute_out,
   output logic [ecal_pkg::SEC_W-1:0]   second_out
);
   import ecal_pkg::*;

   logic [SOD_W-1:0]      sod4_ff;
   logic [MOD_W-1:0]      mod4_ff, mod4_in;
   logic [MOD_W-1:0]      mod5_ff;
   logic [HOUR_W-1:0]     hour5_ff, hour5_in;
   logic [SEC_W-1:0]      sec5_ff, sec5_in;
   logic [HOUR_W-1:0]     hour6_ff;
   logic [MIN_W-1:0]      min6_ff, min6_in;
   logic [SEC_W-1:0]      sec6_ff;
   logic [HOUR_W-1:0]     hour7_ff;
   logic [MIN_W-1:0]      min7_ff;
   logic [SEC_W-1:0]      sec7_ff;
   logic [D60_PROD_W-1:0] prod4;
   logic [D60_PROD_W-1:0] prod5;
   logic [SOD_W-1:0]      diff5;
   logic [MOD_W-1:0]      diff6;

   // Stage four: minute of the day.
   always_comb begin
      prod4   = D60_PROD_W'(sod) * RECIP_60;
      mod4_in = prod4[D60_SHIFT +: MOD_W];
   end

   // Stage five: second of the minute and hour of the day.
   always_comb begin
      diff5    = sod4_ff - SOD_W'(mod4_ff) * SOD_W'(60);
      sec5_in  = diff5[SEC_W-1:0];
      prod5    = D60_PROD_W'(mod4_ff) * RECIP_60;
      hour5_in = prod5[D60_SHIFT +: HOUR_W];
   end

   // Stage six: minute of the hour.
   always_comb begin
      diff6   = mod5_ff - MOD_W'(hour5_ff) * MOD_W'(60);
      min6_in = diff6[MIN_W-1:0];
   end

   // Stage registers; stage seven lines up with the date path.
   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         sod4_ff <= sod;
         mod4_ff <= mod4_in;
      end
      if (ctl.load[4]) begin
         mod5_ff  <= mod4_ff;
         hour5_ff <= hour5_in;
         sec5_ff  <= sec5_in;
      end
      if (ctl.load[5]) begin
         hour6_ff <= hour5_ff;
         min6_ff  <= min6_in;
         sec6_ff  <= sec5_ff;
      end
      if (ctl.load[6]) begin
         hour7_ff <= hour6_ff;
         min7_ff  <= min6_ff;
         sec7_ff  <= sec6_ff;
      end
   end

   assign hour_out   = hour7_ff;
   assign minute_out = min7_ff;
   assign second_out = sec7_ff;

endmodule

// ===== sv/ecal_date.sv =====
// Stages four to seven: Gregorian year, month and day from the day count.
module ecal_date (
   input  logic                          clock,
   input  ecal_pkg::ecal_ctl_type        ctl,
   input  logic [ecal_pkg::DAYS_W-1:0]   days,
   output logic [ecal_pkg::YEAR_W-1:0]   year_out,
   output logic [ecal_pkg::MONTH_W-1:0]  month_out,
   output logic [ecal_pkg::DAY_W-1:0]    day_out
);
   import ecal_pkg::*;

   logic [Z_W-1:0]          z4_in, z4_ff;
   logic [CYC_W-1:0]        cyc4_ff, cyc4_in;
   logic [CYC_W-1:0]        cyc5_ff;
   logic [DOC_W-1:0]        doc5_ff, doc5_in;
   logic [CYC_W-1:0]        cyc6_ff;
   logic [YOC_W-1:0]        yoc6_ff, yoc6_in;
   logic [DOY_W-1:0]        doy6_ff, doy6_in;
   logic [YEAR_W-1:0]       year7_ff, year7_in;
   logic [MONTH_W-1:0]      month7_ff, month7_in;
   logic [DAY_W-1:0]        day7_ff, day7_in;
   logic [D1461_PROD_W-1:0] prod4;
   logic [Z_W-1:0]          diff5;
   logic [DOC_W-1:0]        diff6;
   logic [DOY_W-1:0]        dom7;
   logic [MP_W-1:0]         mp7;

   // Stage four: days since 1968-03-01 and the four-year cycle count.
   // The plain four-year rule holds over this range since 2000 is a leap year.
   always_comb begin
      z4_in   = days + DAY_BASE_OFFSET;
      prod4   = D1461_PROD_W'(z4_in) * RECIP_1461;
      cyc4_in = prod4[D1461_SHIFT +: CYC_W];
   end

   // Stage five: day of the cycle.
   always_comb begin
      diff5   = z4_ff - Z_W'(cyc4_ff) * DAYS_PER_CYCLE;
      doc5_in = diff5[DOC_W-1:0];
   end

   // Stage six: year of the cycle; the leap day closes the fourth year.
   always_comb begin
      yoc6_in = YOC_W'(doc5_ff >= DAYS_PER_YEAR)
              + YOC_W'(doc5_ff >= DOC_W'(730))
              + YOC_W'(doc5_ff >= DOC_W'(1095));
      diff6   = doc5_ff - DOC_W'(yoc6_in) * DAYS_PER_YEAR;
      doy6_in = diff6[DOY_W-1:0];
   end

   // Stage seven: month search over the month starts, then day and year.
   always_comb begin
      mp7 = '0;
      for (int i = 1; i < 12; i++) begin
         if (doy6_ff >= month_start(MP_W'(i))) begin
            mp7 = MP_W'(i);
         end
      end
      dom7    = doy6_ff - month_start(mp7) + DOY_W'(1);
      day7_in = dom7[DAY_W-1:0];
      if (mp7 < MP_W'(10)) begin
         month7_in = mp7 + MONTH_W'(3);
      end else begin
         month7_in = mp7 - MONTH_W'(9);
      end
      year7_in = BASE_YEAR + YEAR_W'({cyc6_ff, 2'b00})
               + YEAR_W'(yoc6_ff) + YEAR_W'(doy6_ff >= JANUARY_START);
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         z4_ff   <= z4_in;
         cyc4_ff <= cyc4_in;
      end
      if (ctl.load[4]) begin
         cyc5_ff <= cyc4_ff;
         doc5_ff <= doc5_in;
      end
      if (ctl.load[5]) begin
         cyc6_ff <= cyc5_ff;
         yoc6_ff <= yoc6_in;
         doy6_ff <= doy6_in;
      end
      if (ctl.load[6]) begin
         year7_ff  <= year7_in;
         month7_ff <= month7_in;
         day7_ff   <= day7_in;
      end
   end

   assign year_out  = year7_ff;
   assign month_out = month7_ff;
   assign day_out   = day7_ff;

endmodule

// ===== sv/epoch_seconds_to_calendar_top.sv =====
// Throughput: one transaction per cycle while the response side is ready; each of
// the seven stages holds its own valid bit and refills as soon as it is empty or its successor moves on.
// Reset clears every stage valid bit and sets the zone offset to 8 hours.
// The configuration port is always ready, and a write takes effect in the cycle after it is presented.
module epoch_seconds_to_calendar_top (
   input  logic        clock,
   input  logic        reset,
   ecal_req_if.sink    req_bus,
   ecal_rsp_if.source  rsp_bus,
   ecal_csr_if.sink    csr_bus
);
   import ecal_pkg::*;

`include "epoch_seconds_to_calendar_top_macros.svh"

   logic [ZONE_W-1:0]     zone_ff, zone_in;
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   ecal_ctl_type          ctl;
   logic [DAYS_W-1:0]     days;
   logic [SOD_W-1:0]      sod;
   logic                  tod_ok;
   logic                  date_ok;
   logic                  year_ok;

   // Zone offset register.
   assign csr_bus.ready = 1'b1;

   always_comb begin
      zone_in = zone_ff;
      if (csr_bus.valid) begin
         zone_in = csr_bus.zone_offset_hours;
      end
   end

   // A stage loads when it is empty or its contents move on.
   always_comb begin
      ctl.load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_bus.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ctl.load[k] = !valid_ff[k] || ctl.load[k+1];
      end
   end

   // Valid bits travel with the data.
   always_comb begin
      valid_in = valid_ff;
      if (ctl.load[0]) begin
         valid_in[0] = req_bus.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (ctl.load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff  <= ZONE_RESET;
         valid_ff <= '0;
      end else begin
         zone_ff  <= zone_in;
         valid_ff <= valid_in;
      end
   end

   assign req_bus.ready = ctl.load[0];
   assign rsp_bus.valid = valid_ff[NUM_STAGES-1];

   // Day split.
   ecal_split u_split (
      .clock             (clock),
      .ctl               (ctl),
      .zone_offset_hours (zone_ff),
      .epoch_seconds     (req_bus.epoch_seconds),
      .days              (days),
      .sod               (sod)
   );

   // Time of day.
   ecal_tod u_tod (
      .clock      (clock),
      .ctl        (ctl),
      .sod        (sod),
      .hour_out   (rsp_bus.hour_out),
      .minute_out (rsp_bus.minute_out),
      .second_out (rsp_bus.second_out)
   );

   // Calendar date.
   ecal_date u_date (
      .clock     (clock),
      .ctl       (ctl),
      .days      (days),
      .year_out  (rsp_bus.year_out),
      .month_out (rsp_bus.month_out),
      .day_out   (rsp_bus.day_out)
   );

   // Range conditions on the response fields.
   assign tod_ok  = (rsp_bus.hour_out < 5'd24) && (rsp_bus.minute_out < 6'd60)
                 && (rsp_bus.second_out < 6'd60);
   assign date_ok = (rsp_bus.month_out >= 4'd1) && (rsp_bus.month_out <= 4'd12)
                 && (rsp_bus.day_out >= 5'd1);
   assign year_ok = (rsp_bus.year_out >= 11'd1970) && (rsp_bus.year_out <= 11'd2038);

   // Result fields stay in their ranges, and a write lands in the zone register.
   `ECAL_ASSERT_IMP(a_tod_range, clock, reset, rsp_bus.valid, tod_ok)
   `ECAL_ASSERT_IMP(a_date_range, clock, reset, rsp_bus.valid, date_ok)
   `ECAL_ASSERT_IMP(a_year_range, clock, reset, rsp_bus.valid, year_ok)
   `ECAL_ASSERT_NXT(a_zone_write, clock, reset, csr_bus.valid && csr_bus.ready, zone_ff == $past(csr_bus.zone_offset_hours))

endmodule
